>>> hw/rtl/csrspmv_pkg.sv
// Shared types, constants and helpers of the CSR sparse matrix-vector row accumulator.
// Depends on nothing; every other file of the block imports it.

package csrspmv_pkg;

    localparam int VEC_DEPTH_DEF  = 4096;
    localparam int FRAC_BITS_DEF  = 16;

    localparam int VALUE_W     = 32;
    localparam int OP_W        = 2;
    localparam int IDX_W       = 12;
    localparam int ROW_W       = 16;
    localparam int MODE_W      = 2;
    localparam int ROWS_W      = 17;
    localparam int COLS_W      = 13;
    localparam int ACC_W       = 64;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 32;
    localparam int IDX_CMP_W   = 21;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [ROWS_W-1:0] MAX_ROWS      = ROWS_W'(65536);
    localparam logic [ROWS_W-1:0] NUM_ROWS_RST  = ROWS_W'(1);
    localparam logic [COLS_W-1:0] NUM_COLS_RST  = COLS_W'(4096);

    // Accumulator saturates symmetrically to +-(2^63-1).
    localparam logic signed [ACC_W:0] SUM_MAX = {2'b00, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W:0] SUM_MIN = {2'b11, {(ACC_W-2){1'b0}}, 1'b1};

    localparam logic signed [ACC_W-1:0] VAL_MAX = ACC_W'({1'b0, {(VALUE_W-1){1'b1}}});
    localparam logic signed [ACC_W-1:0] VAL_MIN = -VAL_MAX - ACC_W'(1);

    typedef enum logic [OP_W-1:0] {
        OP_LOAD    = 2'd0,
        OP_ENTRY   = 2'd1,
        OP_ROW_END = 2'd2
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MODE     = 2'd0,
        CFG_NUM_ROWS = 2'd1,
        CFG_NUM_COLS = 2'd2
    } cfg_idx_t;

    typedef enum logic [MODE_W-1:0] {
        MODE_PRODUCT  = 2'd0,
        MODE_ADD      = 2'd1,
        MODE_SUB      = 2'd2,
        MODE_RESIDUAL = 2'd3
    } mode_t;

    // Work kinds after classification in the front end.
    typedef enum logic [1:0] {
        CLS_LOAD    = 2'd0,
        CLS_MAC     = 2'd1,
        CLS_BAD_COL = 2'd2,
        CLS_ROW_END = 2'd3
    } cls_t;

    typedef struct packed {
        cls_t                      cls;
        logic [IDX_W-1:0]          index;
        logic signed [VALUE_W-1:0] value;
        logic signed [VALUE_W-1:0] rhs;
    } work_t;

    typedef struct packed {
        mode_t              mode;
        logic [ROWS_W-1:0]  num_rows;
        logic [COLS_W-1:0]  num_cols;
    } cfg_t;

    // Zero rows acts as one, more than the counter can name acts as the maximum.
    function automatic logic [ROWS_W-1:0] clamp_rows(input logic [ROWS_W-1:0] n);
        logic [ROWS_W-1:0] r;
        r = n;
        if (n == '0)
            r = ROWS_W'(1);
        else if (n > MAX_ROWS)
            r = MAX_ROWS;
        return r;
    endfunction

    function automatic logic signed [ACC_W-1:0] sat_add(
        input logic signed [ACC_W-1:0] a,
        input logic signed [ACC_W-1:0] b
    );
        logic signed [ACC_W:0]   s;
        logic signed [ACC_W-1:0] r;
        s = $signed({a[ACC_W-1], a}) + $signed({b[ACC_W-1], b});
        if (s > SUM_MAX)
            r = SUM_MAX[ACC_W-1:0];
        else if (s < SUM_MIN)
            r = SUM_MIN[ACC_W-1:0];
        else
            r = s[ACC_W-1:0];
        return r;
    endfunction

endpackage

>>> hw/rtl/csrspmv_if.sv
// Channel interfaces of the row accumulator: item input, result output, register writes.
// Depends on csrspmv_pkg for field widths.

interface csrspmv_in_if import csrspmv_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic [OP_W-1:0]           operation;
    logic [IDX_W-1:0]          index;
    logic signed [VALUE_W-1:0] value;
    logic signed [VALUE_W-1:0] rhs_value;

    modport source (output valid, operation, index, value, rhs_value, input ready);
    modport sink   (input valid, operation, index, value, rhs_value, output ready);
endinterface

interface csrspmv_out_if import csrspmv_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic [ROW_W-1:0]          row_index;
    logic signed [VALUE_W-1:0] row_result;
    logic                      last_row;
    logic                      column_error;
    logic                      saturated;

    modport source (output valid, row_index, row_result, last_row, column_error, saturated,
                    input ready);
    modport sink   (input valid, row_index, row_result, last_row, column_error, saturated,
                    output ready);
endinterface

interface csrspmv_cfg_if import csrspmv_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

>>> hw/rtl/csr_spmv_row_accumulator.sv
// Top level of the CSR sparse matrix-vector row accumulator: registers, front end,
// queue and back end. Depends on csrspmv_pkg, the csrspmv interfaces and all submodules.
//
//  Channel  Direction  Transfer moves
//  -------  ---------  ---------------------------------------------------------
//  item     in         operation, index, value, rhs_value (load, entry, row end)
//  result   out        row_index, row_result, last_row, column_error, saturated
//  cfg      in         index, data: register write (mode, num_rows, num_cols)
//
// One item is taken per clock while the queue has room; the back end runs a five-stage
// pipeline (store read, 32x32 multiply, scale, accumulate, output register) that
// retires one item per cycle while the result is not stalled. A row-end item passes
// the front register, the queue and each back-end stage in turn to the output register.
// Reset clears the row sum, row error flag, row counter and registers; the vector store
// has no reset and must be loaded before entries use it.
// A stalled result holds the back end; the queue and front register keep accepting
// items until they fill.

module csr_spmv_row_accumulator import csrspmv_pkg::*; #(
    parameter int VEC_DEPTH = VEC_DEPTH_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    csrspmv_in_if.sink     item,
    csrspmv_out_if.source  result,
    csrspmv_cfg_if.sink    cfg
);

    cfg_t  cfg_reg;
    logic  q_push, q_ready, q_pop, q_valid;
    work_t q_in, q_head;
    logic [ROWS_W-1:0] rows_clamped;

    // Register writes are always taken.
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode     <= MODE_PRODUCT;
            cfg_reg.num_rows <= NUM_ROWS_RST;
            cfg_reg.num_cols <= NUM_COLS_RST;
        end
        else if (cfg.valid)
        begin
            // keep only the low bits of each register; ignore indices past the list
            unique case (cfg.index)
                CFG_MODE:     cfg_reg.mode     <= mode_t'(cfg.data[MODE_W-1:0]);
                CFG_NUM_ROWS: cfg_reg.num_rows <= cfg.data[ROWS_W-1:0];
                CFG_NUM_COLS: cfg_reg.num_cols <= cfg.data[COLS_W-1:0];
                default: ;
            endcase
        end
    end

    // Classify items: drop unknown operations and loads beyond the store,
    // mark entries whose column is out of range.
    csrspmv_front #(
        .VEC_DEPTH (VEC_DEPTH)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .item    (item),
        .cfg     (cfg_reg),
        .q_push  (q_push),
        .q_data  (q_in),
        .q_ready (q_ready)
    );

    // Decouple classification from the multiply-accumulate pipeline.
    csrspmv_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_data  (q_in),
        .push_ready (q_ready),
        .pop        (q_pop),
        .pop_data   (q_head),
        .pop_valid  (q_valid)
    );

    // Loads write the store in order with entries, so an entry always sees
    // every load that came before it.
    csrspmv_back #(
        .VEC_DEPTH (VEC_DEPTH),
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .q_valid (q_valid),
        .q_data  (q_head),
        .q_pop   (q_pop),
        .result  (result)
    );

    assign rows_clamped = clamp_rows(cfg_reg.num_rows);

    // Hold the result steady while the receiver stalls.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && !result.ready
            |=> (result.valid && $stable(result.row_index) && $stable(result.row_result)
                 && $stable(result.last_row)))
        else $error("result changed while stalled");

    a_last_row: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.last_row
            |-> ({1'b0, result.row_index} == rows_clamped - ROWS_W'(1)))
        else $error("last_row on a row that is not the final one");

    a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.saturated
            |-> (result.row_result == VAL_MAX[VALUE_W-1:0]
                 || result.row_result == VAL_MIN[VALUE_W-1:0]))
        else $error("saturated result not at a range limit");

endmodule

>>> hw/rtl/csrspmv_front.sv
// Front end: accepts input items, classifies them and hands work to the queue.
// Depends on csrspmv_pkg and csrspmv_in_if.

module csrspmv_front import csrspmv_pkg::*; #(
    parameter int VEC_DEPTH = VEC_DEPTH_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    csrspmv_in_if.sink    item,
    input  cfg_t          cfg,
    output logic          q_push,
    output work_t         q_data,
    input  logic          q_ready
);

    logic  f_valid_reg, f_valid_next;
    work_t f_data_reg;
    work_t cls_data;
    logic  keep;
    logic  accept;
    logic  in_store;
    logic  col_ok;

    assign item.ready = !f_valid_reg || q_ready;
    assign accept     = item.valid && item.ready;
    assign q_push     = f_valid_reg;
    assign q_data     = f_data_reg;

    assign in_store = IDX_CMP_W'(item.index) < IDX_CMP_W'(VEC_DEPTH);
    assign col_ok   = ({1'b0, item.index} < cfg.num_cols) && in_store;

    always_comb
    begin
        cls_data.index = item.index;
        cls_data.value = item.value;
        cls_data.rhs   = item.rhs_value;
        cls_data.cls   = CLS_LOAD;
        keep           = 1'b0;
        unique case (item.operation)
            OP_LOAD:
            begin
                cls_data.cls = CLS_LOAD;
                keep         = in_store;
            end
            OP_ENTRY:
            begin
                cls_data.cls = col_ok ? CLS_MAC : CLS_BAD_COL;
                keep         = 1'b1;
            end
            OP_ROW_END:
            begin
                cls_data.cls = CLS_ROW_END;
                keep         = 1'b1;
            end
            default:
            begin
                // unknown operation: drop
                keep = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        f_valid_next = f_valid_reg;
        if (f_valid_reg && q_ready)
            f_valid_next = 1'b0;
        if (accept)
            f_valid_next = keep;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            f_valid_reg <= 1'b0;
        else
            f_valid_reg <= f_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            f_data_reg <= cls_data;
    end

endmodule

>>> hw/rtl/csrspmv_queue.sv
// Short FIFO between front end and back end so each side stalls on its own.
// Depends on csrspmv_pkg for the work item type and depth.

module csrspmv_queue import csrspmv_pkg::*; (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  work_t push_data,
    output logic  push_ready,
    input  logic  pop,
    output work_t pop_data,
    output logic  pop_valid
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = PTR_W + 1;

    work_t              slots [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               do_push, do_pop;

    assign push_ready = count_reg != CNT_W'(QUEUE_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_data   = slots[rd_ptr_reg];
    assign do_push    = push && push_ready;
    assign do_pop     = pop && pop_valid;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + CNT_W'(do_push) - CNT_W'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slots[wr_ptr_reg] <= push_data;
    end

endmodule

>>> hw/rtl/csrspmv_back.sv
// Back end: vector store, multiply-accumulate pipeline, row result and output register.
// Depends on csrspmv_pkg and csrspmv_out_if.

module csrspmv_back import csrspmv_pkg::*; #(
    parameter int VEC_DEPTH = VEC_DEPTH_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  cfg_t           cfg,
    input  logic           q_valid,
    input  work_t          q_data,
    output logic           q_pop,
    csrspmv_out_if.source  result
);

    localparam int AW = $clog2(VEC_DEPTH);

    logic signed [VALUE_W-1:0] vec_mem [VEC_DEPTH];
    logic [AW-1:0]             addr;
    logic                      adv;

    // stage 1: store read
    logic                      s1_valid_reg, s1_valid_next;
    cls_t                      s1_cls_reg;
    logic signed [VALUE_W-1:0] s1_value_reg, s1_rhs_reg;
    logic signed [VALUE_W-1:0] rdata_reg;

    // stage 2: product
    logic                      s2_valid_reg;
    cls_t                      s2_cls_reg;
    logic signed [VALUE_W-1:0] s2_rhs_reg;
    logic signed [ACC_W-1:0]   s2_prod_reg, prod_next;

    // stage 3: scaled product
    logic                      s3_valid_reg;
    cls_t                      s3_cls_reg;
    logic signed [VALUE_W-1:0] s3_rhs_reg;
    logic signed [ACC_W-1:0]   s3_sh_reg, sh_next, bias;

    // stage 4: row state and combined result
    logic signed [ACC_W-1:0]   row_sum_reg, row_sum_next;
    logic                      row_err_reg, row_err_next;
    logic [ROW_W-1:0]          row_cnt_reg, row_cnt_next;
    logic                      res_valid_reg, res_valid_next;
    logic signed [ACC_W-1:0]   res_comb_reg, comb_next;
    logic [ROW_W-1:0]          res_row_reg;
    logic                      res_last_reg, res_err_reg;
    logic [ROWS_W-1:0]         rows;
    logic [ROWS_W-1:0]         cnt_inc;
    logic                      is_last;
    logic                      s4_end;

    // stage 5: output register
    logic                      out_valid_reg, out_valid_next;
    logic [ROW_W-1:0]          out_row_reg;
    logic signed [VALUE_W-1:0] out_result_reg, clip_value;
    logic                      out_last_reg, out_err_reg, out_sat_reg, clip_sat;

    assign adv   = !out_valid_reg || result.ready;
    assign q_pop = adv && q_valid;
    assign addr  = AW'(q_data.index);

    always_ff @(posedge clk)
    begin
        if (q_pop && q_data.cls == CLS_LOAD)
            vec_mem[addr] <= q_data.value;
        if (adv)
            rdata_reg <= vec_mem[addr];
    end

    assign s1_valid_next = q_pop && q_data.cls != CLS_LOAD;

    assign prod_next = s1_value_reg * rdata_reg;
    // truncate toward zero
    assign bias    = s2_prod_reg[ACC_W-1] ? (ACC_W'(1) << FRAC_BITS) - ACC_W'(1) : '0;
    assign sh_next = (s2_prod_reg + bias) >>> FRAC_BITS;

    assign rows    = clamp_rows(cfg.num_rows);
    assign cnt_inc = {1'b0, row_cnt_reg} + ROWS_W'(1);
    assign is_last = {1'b0, row_cnt_reg} == rows - ROWS_W'(1);
    assign s4_end  = adv && s3_valid_reg && s3_cls_reg == CLS_ROW_END;

    always_comb
    begin
        unique case (cfg.mode) inside
            MODE_PRODUCT:             comb_next = row_sum_reg;
            MODE_ADD:                 comb_next = sat_add(ACC_W'(s3_rhs_reg), row_sum_reg);
            MODE_SUB, MODE_RESIDUAL:  comb_next = sat_add(ACC_W'(s3_rhs_reg), -row_sum_reg);
            default:                  comb_next = row_sum_reg;
        endcase
    end

    always_comb
    begin
        row_sum_next = row_sum_reg;
        row_err_next = row_err_reg;
        row_cnt_next = row_cnt_reg;
        if (adv && s3_valid_reg)
        begin
            case (s3_cls_reg)
                CLS_MAC:     row_sum_next = sat_add(row_sum_reg, s3_sh_reg);
                CLS_BAD_COL: row_err_next = 1'b1;
                CLS_ROW_END:
                begin
                    row_sum_next = '0;
                    row_err_next = 1'b0;
                    row_cnt_next = (cnt_inc >= rows) ? '0 : cnt_inc[ROW_W-1:0];
                end
                default: ;
            endcase
        end
    end

    assign res_valid_next = adv ? s3_valid_reg && s3_cls_reg == CLS_ROW_END : res_valid_reg;
    assign out_valid_next = adv ? res_valid_reg : out_valid_reg;

    always_comb
    begin
        clip_sat   = 1'b0;
        clip_value = res_comb_reg[VALUE_W-1:0];
        if (res_comb_reg > VAL_MAX)
        begin
            clip_sat   = 1'b1;
            clip_value = VAL_MAX[VALUE_W-1:0];
        end
        else if (res_comb_reg < VAL_MIN)
        begin
            clip_sat   = 1'b1;
            clip_value = VAL_MIN[VALUE_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            row_sum_reg   <= '0;
            row_err_reg   <= 1'b0;
            row_cnt_reg   <= '0;
        end
        else
        begin
            if (adv)
            begin
                s1_valid_reg <= s1_valid_next;
                s2_valid_reg <= s1_valid_reg;
                s3_valid_reg <= s2_valid_reg;
            end
            res_valid_reg <= res_valid_next;
            out_valid_reg <= out_valid_next;
            row_sum_reg   <= row_sum_next;
            row_err_reg   <= row_err_next;
            row_cnt_reg   <= row_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_cls_reg   <= q_data.cls;
            s1_value_reg <= q_data.value;
            s1_rhs_reg   <= q_data.rhs;
            s2_cls_reg   <= s1_cls_reg;
            s2_rhs_reg   <= s1_rhs_reg;
            s2_prod_reg  <= prod_next;
            s3_cls_reg   <= s2_cls_reg;
            s3_rhs_reg   <= s2_rhs_reg;
            s3_sh_reg    <= sh_next;
            out_row_reg    <= res_row_reg;
            out_result_reg <= clip_value;
            out_last_reg   <= res_last_reg;
            out_err_reg    <= res_err_reg;
            out_sat_reg    <= clip_sat;
        end
        if (s4_end)
        begin
            res_comb_reg <= comb_next;
            res_row_reg  <= row_cnt_reg;
            res_last_reg <= is_last;
            res_err_reg  <= row_err_reg;
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.row_index    = out_row_reg;
    assign result.row_result   = out_result_reg;
    assign result.last_row     = out_last_reg;
    assign result.column_error = out_err_reg;
    assign result.saturated    = out_sat_reg;

endmodule

>>> verif/tb_csr_spmv_row_accumulator.sv
// Self-checking testbench for csr_spmv_row_accumulator: CSR row-streamed sparse matrix-vector
// product with a built-in predictor, random stalls on both channels and register sweeps.
// Depends on csrspmv_pkg, the csrspmv channel interfaces and the block's RTL.

module tb_csr_spmv_row_accumulator;
    import csrspmv_pkg::*;

    // Operation code and register index that the block must ignore.
    localparam logic [OP_W-1:0]      OP_UNUSED     = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 2'd3;

    localparam int CYCLE_LIMIT   = 200000;
    // Queue, front register and five back-end stages, with margin.
    localparam int DRAIN_CYCLES  = 24;
    localparam int REPORT_LIMIT  = 10;
    localparam int PHASE_ITEMS   = 175;

    localparam logic signed [ACC_W:0]   SUM_LIMIT = 65'sh0_7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [ACC_W-1:0] RESULT_HI = 64'sh0000_0000_7FFF_FFFF;
    localparam logic signed [ACC_W-1:0] RESULT_LO = -RESULT_HI - 64'sd1;

    localparam logic signed [VALUE_W-1:0] Q_MAX  = 32'sh7FFF_FFFF;
    localparam logic signed [VALUE_W-1:0] Q_MIN  = 32'sh8000_0000;
    localparam logic signed [VALUE_W-1:0] Q_ONE  = 32'sh0001_0000;
    localparam logic signed [VALUE_W-1:0] Q_HALF = 32'sh0000_8000;

    typedef struct packed {
        logic [OP_W-1:0]           operation;
        logic [IDX_W-1:0]          index;
        logic signed [VALUE_W-1:0] value;
        logic signed [VALUE_W-1:0] rhs_value;
    } spmv_item_t;

    typedef struct packed {
        logic [ROW_W-1:0]          row_index;
        logic signed [VALUE_W-1:0] row_result;
        logic                      last_row;
        logic                      column_error;
        logic                      saturated;
    } row_result_t;

    typedef struct packed {
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
    } reg_write_t;

    logic clk = 1'b0;
    logic rst_n;

    csrspmv_in_if  item_ch ();
    csrspmv_out_if result_ch ();
    csrspmv_cfg_if cfg_ch ();

    csr_spmv_row_accumulator dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    always #1 clk = ~clk;

    // ------------------------------------------------------------------
    // Mirror of the block's state, advanced on every accepted transfer.
    // ------------------------------------------------------------------
    logic signed [VALUE_W-1:0] vec_copy [VEC_DEPTH_DEF];
    logic signed [ACC_W-1:0]   sum_acc;
    logic [ROW_W-1:0]          row_no;
    logic                      row_bad;
    mode_t                     cur_mode;
    logic [ROWS_W-1:0]         cur_rows;
    logic [COLS_W-1:0]         cur_cols;

    row_result_t awaited_rows [$];   // row results still owed by the block
    spmv_item_t  item_backlog [$];   // items waiting for the item driver
    reg_write_t  reg_backlog  [$];   // register writes waiting for the cfg driver

    // Generator's view of which store entries have been loaded.
    bit col_loaded [VEC_DEPTH_DEF];
    int loaded_cols [$];

    int sender_idle_pct;
    int receiver_stall_pct;
    int stimulus_items;
    int items_accepted;
    int rows_checked;
    int mismatch_count;
    int cycle_count;

    // Exact product, scaled down by the fraction bits with truncation toward zero.
    // The product of two 32-bit values always fits, so no clipping is needed here.
    function automatic logic signed [ACC_W-1:0] scaled_product(
        input logic signed [VALUE_W-1:0] a,
        input logic signed [VALUE_W-1:0] b
    );
        logic signed [ACC_W-1:0] p;
        logic [ACC_W-1:0]        m;
        p = $signed({{(ACC_W-VALUE_W){a[VALUE_W-1]}}, a})
            * $signed({{(ACC_W-VALUE_W){b[VALUE_W-1]}}, b});
        m = p[ACC_W-1] ? -p : p;
        m = m >> FRAC_BITS_DEF;
        return p[ACC_W-1] ? -$signed(m) : $signed(m);
    endfunction

    // Add with symmetric clipping to +-(2^63-1).
    function automatic logic signed [ACC_W-1:0] clip_sum(
        input logic signed [ACC_W-1:0] a,
        input logic signed [ACC_W-1:0] b
    );
        logic signed [ACC_W:0] s;
        s = $signed({a[ACC_W-1], a}) + $signed({b[ACC_W-1], b});
        if (s > SUM_LIMIT)
            s = SUM_LIMIT;
        else if (s < -SUM_LIMIT)
            s = -SUM_LIMIT;
        return s[ACC_W-1:0];
    endfunction

    // Advance the mirrored state by one accepted item; queue a row result on row end.
    task automatic accumulate_item(input spmv_item_t it);
        logic signed [ACC_W-1:0] total;
        logic signed [ACC_W-1:0] rhs_ext;
        logic [ROWS_W-1:0]       rows_eff;
        row_result_t             want;
        case (it.operation)
            OP_LOAD:
                vec_copy[it.index] = it.value;
            OP_ENTRY:
                if (it.index < cur_cols)
                    sum_acc = clip_sum(sum_acc, scaled_product(it.value, vec_copy[it.index]));
                else
                    row_bad = 1'b1;
            OP_ROW_END: begin
                rows_eff = (cur_rows == '0) ? ROWS_W'(1)
                         : ((cur_rows > MAX_ROWS) ? MAX_ROWS : cur_rows);
                rhs_ext = {{(ACC_W-VALUE_W){it.rhs_value[VALUE_W-1]}}, it.rhs_value};
                case (cur_mode)
                    MODE_PRODUCT: total = sum_acc;
                    MODE_ADD:     total = clip_sum(rhs_ext, sum_acc);
                    default:      total = clip_sum(rhs_ext, -sum_acc);
                endcase
                want.saturated = 1'b0;
                if (total > RESULT_HI) begin
                    total = RESULT_HI;
                    want.saturated = 1'b1;
                end else if (total < RESULT_LO) begin
                    total = RESULT_LO;
                    want.saturated = 1'b1;
                end
                want.row_index    = row_no;
                want.row_result   = total[VALUE_W-1:0];
                want.last_row     = ({1'b0, row_no} == rows_eff - 1);
                want.column_error = row_bad;
                awaited_rows.push_back(want);
                sum_acc = '0;
                row_bad = 1'b0;
                row_no  = ({1'b0, row_no} + 1 >= rows_eff) ? '0 : row_no + 1'b1;
            end
            default: ;
        endcase
    endtask

    task automatic apply_reg_write(input reg_write_t w);
        case (w.index)
            CFG_MODE:     cur_mode = mode_t'(w.data[MODE_W-1:0]);
            CFG_NUM_ROWS: cur_rows = w.data[ROWS_W-1:0];
            CFG_NUM_COLS: cur_cols = w.data[COLS_W-1:0];
            default: ;
        endcase
    endtask

    // Compare one result transfer with the oldest owed row.
    task automatic check_row(input row_result_t got);
        row_result_t want;
        logic        bad;
        if (awaited_rows.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
                $display("unexpected row result: row %0d result %0d", got.row_index,
                         got.row_result);
        end else begin
            want = awaited_rows.pop_front();
            rows_checked++;
            bad = (got.row_index !== want.row_index) || (got.row_result !== want.row_result)
                || (got.last_row !== want.last_row) || (got.column_error !== want.column_error)
                || (got.saturated !== want.saturated);
            if (bad) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                    $display("row mismatch: exp row=%0d res=%0d last=%0b colerr=%0b sat=%0b | got row=%0d res=%0d last=%0b colerr=%0b sat=%0b",
                             want.row_index, want.row_result, want.last_row,
                             want.column_error, want.saturated, got.row_index,
                             got.row_result, got.last_row, got.column_error, got.saturated);
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Item driver: predict on each transfer, then offer the next item unless
    // the sender idles this cycle. Valid is assigned once per edge at most.
    // ------------------------------------------------------------------
    spmv_item_t cur_item;

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            item_ch.valid     <= 1'b0;
            item_ch.operation <= '0;
            item_ch.index     <= '0;
            item_ch.value     <= '0;
            item_ch.rhs_value <= '0;
        end else begin
            if (item_ch.valid && item_ch.ready) begin
                accumulate_item(cur_item);
                items_accepted++;
            end
            if (!item_ch.valid || item_ch.ready) begin
                if (item_backlog.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
                    cur_item = item_backlog.pop_front();
                    item_ch.valid     <= 1'b1;
                    item_ch.operation <= cur_item.operation;
                    item_ch.index     <= cur_item.index;
                    item_ch.value     <= cur_item.value;
                    item_ch.rhs_value <= cur_item.rhs_value;
                end else begin
                    item_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Register write driver; writes are only queued while the block is idle.
    reg_write_t cur_write;

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            cfg_ch.valid <= 1'b0;
            cfg_ch.index <= '0;
            cfg_ch.data  <= '0;
        end else begin
            if (cfg_ch.valid && cfg_ch.ready)
                apply_reg_write(cur_write);
            if (!cfg_ch.valid || cfg_ch.ready) begin
                if (reg_backlog.size() != 0) begin
                    cur_write = reg_backlog.pop_front();
                    cfg_ch.valid <= 1'b1;
                    cfg_ch.index <= cur_write.index;
                    cfg_ch.data  <= cur_write.data;
                end else begin
                    cfg_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: check each transfer, then drop ready at random to stall.
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            result_ch.ready <= 1'b0;
        end else begin
            if (result_ch.valid && result_ch.ready)
                check_row('{result_ch.row_index, result_ch.row_result, result_ch.last_row,
                            result_ch.column_error, result_ch.saturated});
            result_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    // Watchdog.
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d rows still owed", cycle_count,
                     awaited_rows.size());
            $display("tb_csr_spmv_row_accumulator NOT OK");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic push_item(
        input logic [OP_W-1:0]           op,
        input logic [IDX_W-1:0]          idx,
        input logic signed [VALUE_W-1:0] val,
        input logic signed [VALUE_W-1:0] rhs
    );
        item_backlog.push_back('{op, idx, val, rhs});
        if (op == OP_LOAD && !col_loaded[idx]) begin
            col_loaded[idx] = 1'b1;
            loaded_cols.push_back(idx);
        end
        if (op != OP_UNUSED)
            stimulus_items++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
        reg_backlog.push_back('{idx, d});
    endtask

    // Mix of range extremes, zero, modest magnitudes (up to +-4.0) and raw bit patterns.
    function automatic logic signed [VALUE_W-1:0] pick_value();
        logic signed [VALUE_W-1:0] v;
        case ($urandom_range(7))
            0: v = Q_MAX;
            1: v = Q_MIN;
            2: v = '0;
            3, 4, 5: begin
                v = VALUE_W'($urandom_range(32'h0004_0000));
                if ($urandom_range(1))
                    v = -v;
            end
            default: v = VALUE_W'($urandom);
        endcase
        return v;
    endfunction

    // Column for a matrix entry: mostly a loaded in-range column, sometimes an
    // out-of-range one. Never an in-range column whose store entry is unwritten.
    function automatic logic [IDX_W-1:0] pick_column();
        logic [IDX_W-1:0] c;
        if (cur_cols < VEC_DEPTH_DEF && $urandom_range(9) == 0)
            return IDX_W'($urandom_range(VEC_DEPTH_DEF - 1, cur_cols));
        for (int t = 0; t < 8; t++) begin
            c = IDX_W'(loaded_cols[$urandom_range(loaded_cols.size() - 1)]);
            if (c < cur_cols)
                return c;
        end
        // Column zero is loaded by the directed part.
        return '0;
    endfunction

    // Hold until every queued transfer is done and every owed row has arrived,
    // then let the pipeline empty of entries that produce no result.
    task automatic settle();
        do
            @(negedge clk);
        while (item_backlog.size() != 0 || reg_backlog.size() != 0 || item_ch.valid
               || cfg_ch.valid || awaited_rows.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // One phase: set the idling pattern and registers, then stream mostly
    // well-formed rows with random content, plus ignored codes and empty rows.
    task automatic run_phase(
        input int idle_pct,
        input int stall_pct,
        input logic [CFG_DATA_W-1:0] mode_data,
        input logic [CFG_DATA_W-1:0] rows_data,
        input logic [CFG_DATA_W-1:0] cols_data
    );
        int start;
        int pick;
        sender_idle_pct    = idle_pct;
        receiver_stall_pct = stall_pct;
        write_reg(CFG_MODE, mode_data);
        write_reg(CFG_NUM_ROWS, rows_data);
        write_reg(CFG_NUM_COLS, cols_data);
        settle();
        start = stimulus_items;
        while (stimulus_items - start < PHASE_ITEMS) begin
            pick = $urandom_range(99);
            if (pick < 5) begin
                push_item(OP_UNUSED, IDX_W'($urandom), VALUE_W'($urandom), VALUE_W'($urandom));
            end else if (pick < 10) begin
                push_item(OP_ROW_END, IDX_W'($urandom), VALUE_W'($urandom), pick_value());
            end else begin
                repeat ($urandom_range(2))
                    push_item(OP_LOAD,
                              $urandom_range(1) ? IDX_W'($urandom_range(127))
                                                : IDX_W'($urandom),
                              pick_value(), VALUE_W'($urandom));
                repeat ($urandom_range(6, 1))
                    push_item(OP_ENTRY, pick_column(), pick_value(), VALUE_W'($urandom));
                push_item(OP_ROW_END, IDX_W'($urandom), VALUE_W'($urandom), pick_value());
            end
        end
        settle();
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        rst_n = 1'b0;
        item_ch.valid     = 1'b0;
        item_ch.operation = '0;
        item_ch.index     = '0;
        item_ch.value     = '0;
        item_ch.rhs_value = '0;
        cfg_ch.valid      = 1'b0;
        cfg_ch.index      = '0;
        cfg_ch.data       = '0;
        result_ch.ready   = 1'b0;

        sum_acc  = '0;
        row_no   = '0;
        row_bad  = 1'b0;
        cur_mode = MODE_PRODUCT;
        cur_rows = NUM_ROWS_RST;
        cur_cols = NUM_COLS_RST;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        stimulus_items = 0;
        items_accepted = 0;
        rows_checked   = 0;
        mismatch_count = 0;
        cycle_count    = 0;

        repeat (12) @(posedge clk);
        @(negedge clk) rst_n = 1'b1;

        // Directed part under reset register values (product mode, one row, all columns).
        // Load both range extremes at the first and last store entries, plus exact
        // fractions and alternating bit patterns.
        push_item(OP_LOAD, 12'd0, Q_MAX, Q_MIN);
        push_item(OP_LOAD, 12'hFFF, Q_MIN, Q_MAX);
        push_item(OP_LOAD, 12'd1, Q_ONE, '0);
        push_item(OP_LOAD, 12'd2, -Q_ONE, '0);
        push_item(OP_LOAD, 12'd3, Q_HALF, '0);
        push_item(OP_LOAD, 12'hAAA, 32'sh5555_5555, '0);
        push_item(OP_LOAD, 12'h555, 32'shAAAA_AAAA, '0);
        // Positive overflow of the 32-bit result.
        push_item(OP_ENTRY, 12'd0, Q_MAX, '0);
        push_item(OP_ROW_END, '0, '0, Q_MIN);
        // Two large products on the last store entry that nearly cancel.
        push_item(OP_ENTRY, 12'hFFF, Q_MAX, '0);
        push_item(OP_ENTRY, 12'hFFF, Q_MIN, '0);
        push_item(OP_ROW_END, '0, '0, Q_MAX);
        // In-range mix: 3.0 * 1.0 + 1.5 * -1.0, zero entries on patterned columns.
        push_item(OP_ENTRY, 12'd1, 32'sh0003_0000, '0);
        push_item(OP_ENTRY, 12'd2, 32'sh0001_8000, '0);
        push_item(OP_ENTRY, 12'hAAA, '0, '0);
        push_item(OP_ENTRY, 12'h555, '0, '0);
        push_item(OP_ROW_END, '0, '0, '0);
        // Ignored operation code.
        push_item(OP_UNUSED, 12'hFFF, Q_MIN, Q_MAX);
        // Truncation toward zero of tiny negative and positive products.
        push_item(OP_ENTRY, 12'd3, -32'sd1, '0);
        push_item(OP_ENTRY, 12'd3, 32'sd1, '0);
        push_item(OP_ROW_END, '0, '0, '0);
        // Empty row.
        push_item(OP_ROW_END, 12'hFFF, Q_MAX, Q_MAX);
        settle();

        // Register sweep: every mode, zero and oversized row counts, column limits
        // at both ends, and values with bits above each register's width.
        run_phase(0, 0, CFG_DATA_W'(MODE_ADD), 32'd3, 32'd4096);
        run_phase(69, 0, CFG_DATA_W'(MODE_SUB), 32'd0, 32'd8191);
        run_phase(0, 69, CFG_DATA_W'(MODE_RESIDUAL), 32'h0001_FFFF, 32'd1);
        run_phase(25, 25, CFG_DATA_W'(MODE_PRODUCT), 32'd65536, 32'd0);
        run_phase(0, 0, {30'h3FFF_FFFF, MODE_SUB}, 32'hFFFE_0005, 32'hFFFF_E040);
        run_phase(69, 0, CFG_DATA_W'(MODE_ADD), 32'd7, 32'd100);
        run_phase(0, 69, CFG_DATA_W'(MODE_RESIDUAL), 32'd1, 32'd4095);
        // A write to an index past the register list must change nothing.
        write_reg(CFG_SPARE_IDX, CFG_DATA_W'($urandom));
        run_phase(25, 25, CFG_DATA_W'(MODE_PRODUCT), 32'd2, 32'd4096);

        $display("covered %0d item transfers and %0d row results over 9 phases",
                 items_accepted, rows_checked);
        $display("all modes, row-count and column-limit extremes, stalls on both channels; %0d mismatches",
                 mismatch_count);
        if (mismatch_count == 0 && awaited_rows.size() == 0)
            $display("tb_csr_spmv_row_accumulator OK");
        else
            $display("tb_csr_spmv_row_accumulator NOT OK");
        $finish;
    end

endmodule

>>> sim.f
hw/rtl/csrspmv_pkg.sv
hw/rtl/csrspmv_if.sv
hw/rtl/csrspmv_front.sv
hw/rtl/csrspmv_queue.sv
hw/rtl/csrspmv_back.sv
hw/rtl/csr_spmv_row_accumulator.sv
verif/tb_csr_spmv_row_accumulator.sv
